// ===== rtl/tact_pkg.sv =====
// Shared constants, types and the exponential table of the activation unit.
package tact_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 12;

   // Exponential datapath works in Q30.
   localparam int EXP_FRAC = 30;
   localparam int E_W      = 31;
   localparam int U_W      = DATA_WIDTH + 31 - FRAC_BITS;
   localparam int K_W      = U_W - EXP_FRAC;
   localparam int EXP_STAGES   = 8;
   localparam int SCALE_STAGES = 3;

   localparam logic [E_W-1:0] ONE_Q30   = 31'h4000_0000;
   localparam logic [30:0]    LOG2E_Q30 = 31'd1549082005;
   localparam logic [29:0]    LN2_Q30   = 30'd744261118;
   // ceil(2^30 / 3): exact division by three for values below 2^28.
   localparam logic [28:0]    RECIP3    = 29'd357913942;

   localparam logic       ACT_FORWARD  = 1'b0;
   localparam logic       ACT_BACKWARD = 1'b1;

   localparam logic [1:0] REGION_LOW  = 2'd0;
   localparam logic [1:0] REGION_MID  = 2'd1;
   localparam logic [1:0] REGION_HIGH = 2'd2;

   localparam logic       CSR_ALPHA  = 1'b0;
   localparam logic       CSR_THRESH = 1'b1;

   typedef struct packed {
      logic                  action;
      logic [1:0]            region;
      logic [DATA_WIDTH-1:0] gain;
      logic [DATA_WIDTH-1:0] grad;
      logic [DATA_WIDTH-1:0] beta;
      logic [DATA_WIDTH-1:0] pass;
   } side_type;

   typedef struct packed {
      logic                  saturated;
      logic [1:0]            region;
      logic [DATA_WIDTH-1:0] y_value;
   } result_type;

   // 2^(h/8) in Q30.
   function automatic logic [30:0] pow2_eighths(input logic [2:0] h);
      logic [30:0] v;
      case (h)
         3'd0:    v = 31'd1073741824;
         3'd1:    v = 31'd1170923762;
         3'd2:    v = 31'd1276901417;
         3'd3:    v = 31'd1392470869;
         3'd4:    v = 31'd1518500250;
         3'd5:    v = 31'd1655936265;
         3'd6:    v = 31'd1805811301;
         default: v = 31'd1969251188;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/terelu_activation_unit_top.sv =====
// Top level of the thresholded exponential ReLU unit: registers, region decode and pipeline.
//
//  Channel  Direction  Ports                 Contents
//  req      in         req_t{valid,ready}    tdata: x, beta, grad; tuser: action
//  rsp      out        rsp_t{valid,ready}    tdata: y; tuser: region, saturated
//  csr      in         csr_p*                alpha gain at 0x0, upper threshold at 0x4
//
// One word is taken per cycle while the sink keeps up; the pipeline has one decode stage,
// eight exponential stages, three multiply stages and the output register.
// The exponential's chain of dependent multiplies sets the depth; no stage holds more
// than one multiply.
// Reset is synchronous and clears the valid bits and restores alpha and the threshold to 1.0.
// When the sink stalls, the skid word absorbs the word in flight and the pipeline holds.
module terelu_activation_unit_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata from bit 0: x_value[15:0], beta_value[15:0], grad_out[15:0]
   input  logic [3*tact_pkg::DATA_WIDTH-1:0]   req_tdata,
   // tuser: action
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: y_value[15:0]
   output logic [tact_pkg::DATA_WIDTH-1:0]     rsp_tdata,
   // tuser from bit 0: region[1:0], saturated
   output logic [2:0]                          rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [2:0]                          csr_paddr,
   input  logic [31:0]                         csr_pwdata,
   output logic [31:0]                         csr_prdata,
   output logic                                csr_pready
);

   localparam int DW = tact_pkg::DATA_WIDTH;

   logic [DW-1:0] alpha_ff;
   logic [DW-2:0] thresh_ff;
   logic          csr_wr;

   logic                  adv;
   logic signed [DW-1:0]  x_s;
   logic [DW-1:0]         mag_in;
   tact_pkg::side_type    side_in;
   logic                  vld0_ff;
   logic [DW-1:0]         mag0_ff;
   tact_pkg::side_type    side0_ff;

   logic                  exp_vld;
   logic [tact_pkg::E_W-1:0] exp_val;
   tact_pkg::side_type    exp_side;
   logic                  sc_vld;
   tact_pkg::result_type  sc_result;
   tact_pkg::result_type  rsp_result;

   // Registers are word addressed; the byte offset within a word is ignored.
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= DW'(1) << tact_pkg::FRAC_BITS;
         thresh_ff <= (DW-1)'(1) << tact_pkg::FRAC_BITS;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            tact_pkg::CSR_ALPHA:  alpha_ff  <= csr_pwdata[DW-1:0];
            tact_pkg::CSR_THRESH: thresh_ff <= csr_pwdata[DW-2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         tact_pkg::CSR_ALPHA:  csr_prdata = 32'(signed'(alpha_ff));
         tact_pkg::CSR_THRESH: csr_prdata = 32'(thresh_ff);
         default:              csr_prdata = 32'd0;
      endcase
      if (csr_paddr[1:0] != 2'd0) begin
         csr_prdata = csr_prdata;
      end
   end

   // Region decode and the magnitude of the exponent's argument.
   assign x_s = req_tdata[DW-1:0];

   always_comb begin
      side_in.action = req_tuser[0];
      side_in.grad   = req_tdata[3*DW-1:2*DW];
      side_in.beta   = req_tdata[2*DW-1:DW];
      side_in.pass   = (req_tuser[0] == tact_pkg::ACT_BACKWARD) ?
                       req_tdata[3*DW-1:2*DW] : req_tdata[DW-1:0];
      if (x_s[DW-1] || (x_s == DW'(0))) begin
         side_in.region = tact_pkg::REGION_LOW;
         side_in.gain   = alpha_ff;
         mag_in         = DW'(0) - DW'(x_s);
      end else if (x_s[DW-2:0] < thresh_ff) begin
         side_in.region = tact_pkg::REGION_MID;
         side_in.gain   = alpha_ff;
         mag_in         = DW'(0);
      end else begin
         side_in.region = tact_pkg::REGION_HIGH;
         side_in.gain   = req_tdata[2*DW-1:DW];
         mag_in         = DW'(x_s) - DW'(thresh_ff);
      end
   end

   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag0_ff  <= mag_in;
         side0_ff <= side_in;
      end
   end

   tact_exp_pipe u_exp (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (vld0_ff),
      .in_mag   (mag0_ff),
      .in_side  (side0_ff),
      .out_vld  (exp_vld),
      .out_exp  (exp_val),
      .out_side (exp_side)
   );

   tact_scale_pipe u_scale (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .threshold  (thresh_ff),
      .in_vld     (exp_vld),
      .in_exp     (exp_val),
      .in_side    (exp_side),
      .out_vld    (sc_vld),
      .out_result (sc_result)
   );

   tact_out_buf u_out (
      .clock      (clock),
      .reset      (reset),
      .in_vld     (sc_vld),
      .in_result  (sc_result),
      .out_ready  (rsp_tready),
      .out_vld    (rsp_tvalid),
      .out_result (rsp_result),
      .adv        (adv)
   );

   assign rsp_tdata = rsp_result.y_value;
   assign rsp_tuser = {rsp_result.saturated, rsp_result.region};

endmodule

// ===== rtl/tact_exp_pipe.sv =====
// Pipelined e^(-a) in Q30: base-two split, table lookup and Horner polynomial.
module tact_exp_pipe (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                in_vld,
   input  logic [tact_pkg::DATA_WIDTH-1:0]     in_mag,
   input  tact_pkg::side_type                  in_side,
   output logic                                out_vld,
   output logic [tact_pkg::E_W-1:0]            out_exp,
   output tact_pkg::side_type                  out_side
);

   localparam int DW = tact_pkg::DATA_WIDTH;
   localparam int S  = tact_pkg::EXP_STAGES;
   localparam int KW = tact_pkg::K_W;
   localparam int UW = tact_pkg::U_W;

   logic               vld_ff  [S];
   tact_pkg::side_type side_ff [S];

   // Stage 1: u = a * log2(e).
   logic [DW+30:0] prod1_in;
   logic [UW-1:0]  u_in;
   logic [KW-1:0]  k1_ff;
   logic [29:0]    f1_ff;

   // Stage 2: z = g * ln2.
   logic [29:0]    w_in;
   logic [56:0]    prod2_in;
   logic [26:0]    z2_ff;
   logic [2:0]     h2_ff;
   logic [KW-1:0]  k2_ff;
   logic           fz2_ff;

   // Stage 3: z * (1 + z/4).
   logic [30:0]    p4_in;
   logic [57:0]    prod3_in;
   logic [27:0]    v3_ff;
   logic [26:0]    z3_ff;
   logic [2:0]     h3_ff;
   logic [KW-1:0]  k3_ff;
   logic           fz3_ff;

   // Stage 4: divide by three through the reciprocal.
   logic [56:0]    prod4_in;
   logic [30:0]    p3_ff;
   logic [26:0]    z4_ff;
   logic [2:0]     h4_ff;
   logic [KW-1:0]  k4_ff;
   logic           fz4_ff;

   // Stage 5: p2 = 1 + (z * p3) / 2.
   logic [57:0]    prod5_in;
   logic [30:0]    p2_ff;
   logic [26:0]    z5_ff;
   logic [2:0]     h5_ff;
   logic [KW-1:0]  k5_ff;
   logic           fz5_ff;

   // Stage 6: p1 = 1 + z * p2.
   logic [57:0]    prod6_in;
   logic [30:0]    p1_ff;
   logic [2:0]     h6_ff;
   logic [KW-1:0]  k6_ff;
   logic           fz6_ff;

   // Stage 7: table times polynomial.
   logic [61:0]    prod7_in;
   logic [31:0]    m7_ff;
   logic [KW-1:0]  k7_ff;
   logic           fz7_ff;

   // Stage 8: binary exponent shift.
   logic [KW:0]              ksh_in;
   logic [tact_pkg::E_W-1:0] e_in;
   logic [tact_pkg::E_W-1:0] e8_ff;

   assign prod1_in = (DW+31)'(in_mag) * (DW+31)'(tact_pkg::LOG2E_Q30);
   assign u_in     = prod1_in[DW+30:tact_pkg::FRAC_BITS];

   assign w_in     = 30'(31'(tact_pkg::ONE_Q30) - {1'b0, f1_ff});
   assign prod2_in = 57'(w_in[26:0]) * 57'(tact_pkg::LN2_Q30);

   assign p4_in    = tact_pkg::ONE_Q30 + 31'(z2_ff >> 2);
   assign prod3_in = 58'(z2_ff) * 58'(p4_in);

   assign prod4_in = 57'(v3_ff) * 57'(tact_pkg::RECIP3);

   assign prod5_in = 58'(z4_ff) * 58'(p3_ff);

   assign prod6_in = 58'(z5_ff) * 58'(p2_ff);

   assign prod7_in = 62'(tact_pkg::pow2_eighths(h6_ff)) * 62'(p1_ff);

   assign ksh_in = (KW+1)'(k7_ff) + (KW+1)'(1);
   assign e_in   = fz7_ff ? (tact_pkg::ONE_Q30 >> k7_ff) : tact_pkg::E_W'(m7_ff >> ksh_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < S; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i < S; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < S; i++) begin
            side_ff[i] <= side_ff[i-1];
         end

         k1_ff  <= u_in[UW-1:30];
         f1_ff  <= u_in[29:0];

         z2_ff  <= prod2_in[56:30];
         h2_ff  <= w_in[29:27];
         k2_ff  <= k1_ff;
         fz2_ff <= (f1_ff == 30'd0);

         v3_ff  <= prod3_in[57:30];
         z3_ff  <= z2_ff;
         h3_ff  <= h2_ff;
         k3_ff  <= k2_ff;
         fz3_ff <= fz2_ff;

         p3_ff  <= tact_pkg::ONE_Q30 + 31'(prod4_in[56:30]);
         z4_ff  <= z3_ff;
         h4_ff  <= h3_ff;
         k4_ff  <= k3_ff;
         fz4_ff <= fz3_ff;

         p2_ff  <= tact_pkg::ONE_Q30 + 31'(prod5_in[57:31]);
         z5_ff  <= z4_ff;
         h5_ff  <= h4_ff;
         k5_ff  <= k4_ff;
         fz5_ff <= fz4_ff;

         p1_ff  <= tact_pkg::ONE_Q30 + 31'(prod6_in[57:30]);
         h6_ff  <= h5_ff;
         k6_ff  <= k5_ff;
         fz6_ff <= fz5_ff;

         m7_ff  <= prod7_in[61:30];
         k7_ff  <= k6_ff;
         fz7_ff <= fz6_ff;

         e8_ff  <= e_in;
      end
   end

   assign out_vld  = vld_ff[S-1];
   assign out_exp  = e8_ff;
   assign out_side = side_ff[S-1];

endmodule

// ===== rtl/tact_scale_pipe.sv =====
// Gain and gradient multiplies, rounding and saturation of the result word.
module tact_scale_pipe (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic [tact_pkg::DATA_WIDTH-2:0]     threshold,
   input  logic                                in_vld,
   input  logic [tact_pkg::E_W-1:0]            in_exp,
   input  tact_pkg::side_type                  in_side,
   output logic                                out_vld,
   output tact_pkg::result_type                out_result
);

   localparam int DW   = tact_pkg::DATA_WIDTH;
   localparam int FB   = tact_pkg::FRAC_BITS;
   localparam int S    = tact_pkg::SCALE_STAGES;
   localparam int EF   = tact_pkg::EXP_FRAC;
   localparam int PA_W = DW + 32;
   localparam int B2_W = DW + 2;
   localparam int PB_W = DW + B2_W;
   localparam int ISH  = EF - FB;

   localparam logic signed [PA_W-1:0] HALF_A = PA_W'(1) << (EF - 1);
   localparam logic signed [PB_W-1:0] HALF_B = PB_W'(1) << (FB - 1);
   localparam logic signed [PB_W-1:0] Y_MAX  = (PB_W'(1) << (DW - 1)) - PB_W'(1);
   localparam logic signed [PB_W-1:0] Y_MIN  = -Y_MAX - PB_W'(1);
   localparam logic [tact_pkg::E_W-1:0] HALF_I = tact_pkg::E_W'(1) << (ISH - 1);
   localparam logic signed [DW-1:0]   ONE_FX = DW'(1) << FB;

   logic               vld_ff  [S];
   tact_pkg::side_type side_ff [S];

   // Stage 1: gain times e (or e minus one), and the upper-region inner term.
   logic signed [DW-1:0]       gain_s;
   logic signed [31:0]         op_a;
   logic signed [PA_W-1:0]     prod_a_in;
   logic [tact_pkg::E_W-1:0]   diff_in;
   logic [tact_pkg::E_W-1:0]   rdiff_in;
   logic [DW:0]                inner_in;
   logic signed [PA_W-1:0]     prod_a_ff;
   logic [DW:0]                inner_ff;

   // Stage 2: round the first product and pick the second multiply's operands.
   logic signed [PA_W-1:0]     sum_a;
   logic signed [PA_W-1:0]     round_a;
   logic signed [B2_W-1:0]     ra;
   logic signed [DW-1:0]       b1_in;
   logic signed [B2_W-1:0]     b2_in;
   logic signed [DW-1:0]       b1_ff;
   logic signed [B2_W-1:0]     b2_ff;

   // Stage 3: second multiply.
   logic signed [PB_W-1:0]     prod_b_in;
   logic signed [PB_W-1:0]     prod_b_ff;

   // Output: round and clip.
   logic signed [PB_W-1:0]     sum_b;
   logic signed [PB_W-1:0]     round_b;

   assign gain_s    = in_side.gain;
   assign op_a      = (in_side.action == tact_pkg::ACT_BACKWARD) ?
                      32'(in_exp) : 32'(in_exp) - 32'(tact_pkg::ONE_Q30);
   assign prod_a_in = PA_W'(gain_s) * PA_W'(op_a);
   assign diff_in   = tact_pkg::ONE_Q30 - in_exp;
   assign rdiff_in  = (diff_in + HALF_I) >> ISH;
   assign inner_in  = (DW+1)'(threshold) + (DW+1)'(rdiff_in);

   assign sum_a   = prod_a_ff + HALF_A;
   assign round_a = sum_a >>> EF;
   assign ra      = B2_W'(round_a);

   always_comb begin
      if (side_ff[0].action == tact_pkg::ACT_BACKWARD) begin
         b1_in = side_ff[0].grad;
         b2_in = ra;
      end else if (side_ff[0].region == tact_pkg::REGION_HIGH) begin
         b1_in = side_ff[0].beta;
         b2_in = B2_W'(inner_ff);
      end else begin
         // Scaling by one keeps the lower forward result on the common path.
         b1_in = ONE_FX;
         b2_in = ra;
      end
   end

   assign prod_b_in = PB_W'(b1_ff) * PB_W'(b2_ff);

   assign sum_b   = prod_b_ff + HALF_B;
   assign round_b = sum_b >>> FB;

   always_comb begin
      out_result.region = side_ff[S-1].region;
      if (side_ff[S-1].region == tact_pkg::REGION_MID) begin
         out_result.y_value   = side_ff[S-1].pass;
         out_result.saturated = 1'b0;
      end else if (round_b > Y_MAX) begin
         out_result.y_value   = DW'(Y_MAX);
         out_result.saturated = 1'b1;
      end else if (round_b < Y_MIN) begin
         out_result.y_value   = DW'(Y_MIN);
         out_result.saturated = 1'b1;
      end else begin
         out_result.y_value   = DW'(round_b);
         out_result.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < S; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_vld;
         for (int i = 1; i < S; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < S; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         prod_a_ff <= prod_a_in;
         inner_ff  <= inner_in;
         b1_ff     <= b1_in;
         b2_ff     <= b2_in;
         prod_b_ff <= prod_b_in;
      end
   end

   assign out_vld = vld_ff[S-1];

endmodule

// ===== rtl/tact_out_buf.sv =====
// Output register with a one-word skid stage that decouples the pipeline from the sink.
module tact_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  tact_pkg::result_type  in_result,
   input  logic                  out_ready,
   output logic                  out_vld,
   output tact_pkg::result_type  out_result,
   output logic                  adv
);

   logic                 out_vld_ff;
   logic                 skid_vld_ff;
   tact_pkg::result_type out_ff;
   tact_pkg::result_type skid_ff;
   logic                 take;
   logic                 load_out;

   assign take     = out_vld_ff & out_ready;
   assign load_out = !out_vld_ff | out_ready;
   // The pipeline moves only while the skid stage is empty.
   assign adv      = !skid_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (in_vld) begin
         if (load_out) begin
            out_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (out_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (in_vld) begin
         if (load_out) begin
            out_ff <= in_result;
         end else begin
            skid_ff <= in_result;
         end
      end
   end

   assign out_vld    = out_vld_ff;
   assign out_result = out_ff;

endmodule
